### src/pcd_pkg.sv
`default_nettype none

package pcd_pkg;

  // Access kinds carried by the command field
  typedef enum logic [1:0] {
    CMD_PORT_WRITE  = 2'd0,
    CMD_PROM_NIBBLE = 2'd1,
    CMD_ROW_LOAD    = 2'd2,
    CMD_IDLE        = 2'd3
  } cmd_e;

  // Chip numbers in the high nibble of the port
  localparam logic [3:0] CHIP_SWITCH  = 4'h2;
  localparam logic [3:0] CHIP_LAMP    = 4'h3;
  localparam logic [3:0] CHIP_SOL     = 4'h4;
  localparam logic [3:0] CHIP_NVRAM   = 4'h6;
  localparam logic [3:0] CHIP_DISPLAY = 4'hd;

  // Solenoid chip control lines
  localparam logic [3:0] LINE_SOL_LAST = 4'hb;
  localparam logic [3:0] LINE_RAM_DIS  = 4'hd;
  localparam logic [3:0] LINE_RAM_WM   = 4'he;

  // Display controller commands in the high nibble of the data
  localparam logic [3:0] DISP_CMD_B = 4'hd;
  localparam logic [3:0] DISP_CMD_A = 4'he;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIP_ZERO = 2'd0;
  localparam logic [1:0] CFG_DIP_ONE  = 2'd1;
  localparam logic [1:0] CFG_DIP_TWO  = 2'd2;

  localparam logic [4:0] COUNT_TOP     = 5'd16;
  localparam logic [4:0] STROBE_NONE   = 5'h1f;
  localparam int unsigned SOL_ENABLE   = 16;

  // Result beat
  typedef struct packed {
    logic [3:0]  read_value;
    logic        lamp_valid;
    logic [3:0]  lamp_address;
    logic [3:0]  lamp_value;
    logic        display_valid;
    logic [5:0]  display_position;
    logic [3:0]  display_digit;
    logic [16:0] solenoid_bits;
    logic [2:0]  switch_strobe;
    logic [9:0]  prom_address;
  } result_t;

endpackage

`default_nettype wire

### src/pinball_cpu_io_port_decoder_core.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o  command, port, data, row_index, row_value
// out       source     out_valid_o/out_stall_i  read_value .. prom_address
// cfg       sink       cfg_we_i               cfg_index_i, cfg_data_i
//
// One beat a cycle while the output is not stalled: an access is decoded straight
// from the input beat and the state registers into the result register, which
// drives the outputs. The NVRAM read side is a registered read that always
// tracks the current NVRAM address, so a read beat does not wait on it. Reset is
// asynchronous; NVRAM entries carry valid bits cleared at once, no sweep.
// A stalled result holds in the output register and stalls the input side.

module pinball_cpu_io_port_decoder_core #(
  parameter int unsigned NVRAM_WORDS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,

  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  port_i,
  input  wire logic [7:0]  data_i,
  input  wire logic [2:0]  row_index_i,
  input  wire logic [7:0]  row_value_i,

  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [3:0]  read_value_o,
  output      logic        lamp_valid_o,
  output      logic [3:0]  lamp_address_o,
  output      logic [3:0]  lamp_value_o,
  output      logic        display_valid_o,
  output      logic [5:0]  display_position_o,
  output      logic [3:0]  display_digit_o,
  output      logic [16:0] solenoid_bits_o,
  output      logic [2:0]  switch_strobe_o,
  output      logic [9:0]  prom_address_o
);

  localparam int unsigned NvAw = (NVRAM_WORDS > 1) ? $clog2(NVRAM_WORDS) : 1;

  // Wrap an 8-bit NVRAM address into the store: constant table built at
  // elaboration.
  function automatic logic [256*NvAw-1:0] build_mod_tbl();
    logic [256*NvAw-1:0] t;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      t[i*NvAw +: NvAw] = NvAw'(i % NVRAM_WORDS);
    end
    return t;
  endfunction

  localparam logic [256*NvAw-1:0] ModTbl = build_mod_tbl();

  // Configuration
  logic [7:0] dip0_q, dip1_q, dip2_q;

  // Architectural state
  logic [3:0]  acc_q, acc_d;
  logic [3:0]  latch_q, latch_d;
  logic [4:0]  strobe_q, strobe_d;     // two's complement, -1..11
  logic [2:0]  col_q, col_d;
  logic [9:0]  prom_q, prom_d;
  logic [16:0] sol_q, sol_d;
  logic        ram_dis_q, ram_dis_d;
  logic        ram_wm_q, ram_wm_d;
  logic [7:0]  ram_addr_q, ram_addr_d;
  logic [7:0]  rows_q [8];
  logic [7:0]  rows_d [8];
  logic [4:0]  cnt_a_q, cnt_a_d;
  logic [4:0]  cnt_b_q, cnt_b_d;

  // NVRAM and its registered read port
  logic [3:0]             nv_mem_q [NVRAM_WORDS];
  logic [NVRAM_WORDS-1:0] nv_vld_q;
  logic [3:0]             nv_rd_q;
  logic                   nv_rd_vld_q;
  logic                   nv_byp_q;
  logic [3:0]             nv_byp_data_q;
  logic                   nv_we;
  logic [NvAw-1:0]        nv_idx;
  logic [3:0]             nv_cur;

  // Output register
  logic                   out_valid_q;
  pcd_pkg::result_t       res_q, res_d;

  logic accept;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // Current NVRAM entry at the present address: bypass a write of last cycle,
  // and read zero from an entry never written.
  assign nv_cur = nv_byp_q ? nv_byp_data_q : (nv_rd_vld_q ? nv_rd_q : 4'h0);

  // Index of the next address: also the write address of a NVRAM write beat.
  assign nv_idx = ModTbl[ram_addr_d*NvAw +: NvAw];

  always_comb begin
    logic [3:0] chip;
    logic [3:0] line;
    logic       sos;
    logic       en;
    logic       rw;
    logic [2:0] grp;
    logic [7:0] row;
    logic [7:0] dip;
    logic [3:0] inv;

    chip = port_i[7:4];
    line = port_i[3:0];
    sos  = data_i[4];
    en   = data_i[3];
    rw   = data_i[6];
    grp  = 3'b111 ^ {data_i[7], data_i[5], data_i[4]};
    row  = rows_q[col_q];
    inv  = ~latch_q;

    priority if (strobe_q == 5'd0) begin
      dip = dip0_q;
    end else if (strobe_q == 5'd1) begin
      dip = dip1_q;
    end else begin
      dip = dip2_q;
    end

    acc_d      = acc_q;
    latch_d    = latch_q;
    strobe_d   = strobe_q;
    col_d      = col_q;
    prom_d     = prom_q;
    sol_d      = sol_q;
    ram_dis_d  = ram_dis_q;
    ram_wm_d   = ram_wm_q;
    ram_addr_d = ram_addr_q;
    rows_d     = rows_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    nv_we      = 1'b0;

    res_d                  = '0;

    if (accept) begin
      unique case (pcd_pkg::cmd_e'(command_i))
        pcd_pkg::CMD_PORT_WRITE: begin
          acc_d = data_i[3:0];
          unique case (chip)
            pcd_pkg::CHIP_SWITCH: begin
              priority if (line < 4'd6 && !en) begin
                col_d = line[2:0] + 3'd1;
              end else if (!sos && line[3] && col_q != 3'd0) begin
                acc_d = {~row[line[2:0]], acc_d[2:0]};
              end else begin
                col_d = 3'd0;
              end
            end
            pcd_pkg::CHIP_LAMP: begin
              if (rw) begin
                if (grp[0]) latch_d = acc_d;
                if (grp[1]) begin
                  strobe_d = (acc_d < 4'd12) ? {1'b0, acc_d} : pcd_pkg::STROBE_NONE;
                  if (!strobe_d[4] && strobe_d != 5'd0) begin
                    inv                    = ~latch_d;
                    res_d.lamp_valid       = 1'b1;
                    res_d.lamp_address     = strobe_d[3:0] - 4'd1;
                    res_d.lamp_value       = inv;
                    if (strobe_d == 5'd1) begin
                      sol_d[pcd_pkg::SOL_ENABLE] = (inv[1:0] == 2'b01);
                    end
                  end
                end
                if (grp[2]) prom_d[9:8] = acc_d[1:0];
              end else begin
                acc_d = 4'h0;
                if (!strobe_q[4] && strobe_q < 5'd3) begin
                  if (grp[0]) acc_d = acc_d ^ dip[3:0];
                  if (grp[1]) acc_d = acc_d ^ dip[7:4];
                end
                if (grp[2]) acc_d = 4'h8 ^ rows_q[7][7:4];
              end
            end
            pcd_pkg::CHIP_SOL: begin
              if (sos) begin
                priority if (line <= pcd_pkg::LINE_SOL_LAST) begin
                  sol_d[line] = !en;
                end else if (line == pcd_pkg::LINE_RAM_DIS) begin
                  ram_dis_d = en;
                end else if (line == pcd_pkg::LINE_RAM_WM) begin
                  ram_wm_d = en;
                end else begin
                  ram_wm_d = ram_wm_q;
                end
              end
            end
            pcd_pkg::CHIP_NVRAM: begin
              if (rw) begin
                if (grp[0]) ram_addr_d[3:0] = acc_d;
                if (grp[1]) ram_addr_d[7:4] = acc_d;
                nv_we = !ram_dis_q && ram_wm_q && grp[2];
              end else begin
                acc_d = (!ram_dis_q && grp[0]) ? nv_cur : 4'hf;
              end
            end
            pcd_pkg::CHIP_DISPLAY: begin
              priority if (data_i[7:4] == pcd_pkg::DISP_CMD_B) begin
                priority if (cnt_b_q >= 5'd3 && cnt_b_q <= 5'd8) begin
                  res_d.display_valid    = 1'b1;
                  res_d.display_position = {1'b0, cnt_b_q} - 6'd3;
                end else if (cnt_b_q >= 5'd11) begin
                  res_d.display_valid    = 1'b1;
                  res_d.display_position = {1'b0, cnt_b_q} - 6'd5;
                end else begin
                  res_d.display_valid    = 1'b0;
                end
                cnt_b_d = (cnt_b_q <= 5'd1) ? pcd_pkg::COUNT_TOP : cnt_b_q - 5'd1;
              end else if (data_i[7:4] == pcd_pkg::DISP_CMD_A) begin
                res_d.display_valid = 1'b1;
                priority if (cnt_a_q <= 5'd2) begin
                  res_d.display_position = {1'b0, cnt_a_q} + 6'd39;
                end else if (cnt_a_q <= 5'd8) begin
                  res_d.display_position = {1'b0, cnt_a_q} + 6'd9;
                end else if (cnt_a_q <= 5'd10) begin
                  res_d.display_position = {1'b0, cnt_a_q} + 6'd23;
                end else begin
                  res_d.display_position = {1'b0, cnt_a_q} + 6'd7;
                end
                cnt_a_d = (cnt_a_q <= 5'd1) ? pcd_pkg::COUNT_TOP : cnt_a_q - 5'd1;
              end else begin
                cnt_a_d = cnt_a_q;
              end
              if (res_d.display_valid) res_d.display_digit = acc_d;
            end
            default: begin
              acc_d = data_i[3:0];
            end
          endcase
        end
        pcd_pkg::CMD_PROM_NIBBLE: begin
          if (port_i[0]) begin
            prom_d[7:4] = ~data_i[3:0];
          end else begin
            prom_d[3:0] = ~data_i[3:0];
          end
        end
        pcd_pkg::CMD_ROW_LOAD: begin
          rows_d[row_index_i] = row_value_i;
        end
        pcd_pkg::CMD_IDLE: begin
          acc_d = acc_q;
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
    end

    res_d.read_value    = acc_d;
    res_d.solenoid_bits = sol_d;
    res_d.switch_strobe = col_d;
    res_d.prom_address  = prom_d;
  end

  // Config registers and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dip0_q     <= '0;
      dip1_q     <= '0;
      dip2_q     <= '0;
      acc_q      <= '0;
      latch_q    <= '0;
      strobe_q   <= '0;
      col_q      <= '0;
      prom_q     <= '0;
      sol_q      <= '0;
      ram_dis_q  <= 1'b0;
      ram_wm_q   <= 1'b0;
      ram_addr_q <= '0;
      rows_q     <= '{default: '0};
      cnt_a_q    <= pcd_pkg::COUNT_TOP;
      cnt_b_q    <= pcd_pkg::COUNT_TOP;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pcd_pkg::CFG_DIP_ZERO: dip0_q <= cfg_data_i;
          pcd_pkg::CFG_DIP_ONE:  dip1_q <= cfg_data_i;
          pcd_pkg::CFG_DIP_TWO:  dip2_q <= cfg_data_i;
          default:               dip0_q <= dip0_q;
        endcase
      end
      acc_q      <= acc_d;
      latch_q    <= latch_d;
      strobe_q   <= strobe_d;
      col_q      <= col_d;
      prom_q     <= prom_d;
      sol_q      <= sol_d;
      ram_dis_q  <= ram_dis_d;
      ram_wm_q   <= ram_wm_d;
      ram_addr_q <= ram_addr_d;
      rows_q     <= rows_d;
      cnt_a_q    <= cnt_a_d;
      cnt_b_q    <= cnt_b_d;
    end
  end

  // NVRAM array: write at the new address, read the new address every cycle
  always_ff @(posedge clk_i) begin
    if (nv_we) begin
      nv_mem_q[nv_idx] <= acc_d;
    end
    nv_rd_q       <= nv_mem_q[nv_idx];
    nv_byp_data_q <= acc_d;
  end

  // NVRAM valid bits and read-port control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_vld_q    <= '0;
      nv_rd_vld_q <= 1'b0;
      nv_byp_q    <= 1'b0;
    end else begin
      if (nv_we) begin
        nv_vld_q[nv_idx] <= 1'b1;
      end
      nv_rd_vld_q <= nv_vld_q[nv_idx];
      nv_byp_q    <= nv_we;
    end
  end

  // Result register: advance on accept, hold while stalled, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign read_value_o       = res_q.read_value;
  assign lamp_valid_o       = res_q.lamp_valid;
  assign lamp_address_o     = res_q.lamp_address;
  assign lamp_value_o       = res_q.lamp_value;
  assign display_valid_o    = res_q.display_valid;
  assign display_position_o = res_q.display_position;
  assign display_digit_o    = res_q.display_digit;
  assign solenoid_bits_o    = res_q.solenoid_bits;
  assign switch_strobe_o    = res_q.switch_strobe;
  assign prom_address_o     = res_q.prom_address;

endmodule

`default_nettype wire

### sim/pinball_cpu_io_port_decoder_core_tb.sv
`default_nettype none

module pinball_cpu_io_port_decoder_core_tb;
  import pcd_pkg::*;

  localparam int NVRAM_DEPTH  = 256;
  localparam int LAMP_STROBES = 12;   // strobe values 12 and up park the strobe at -1
  localparam int TAIL_CYCLES  = 8;    // result register plus margin
  localparam int MAX_REPORTS  = 10;

  // One CPU access as driven onto the input channel
  typedef struct {
    cmd_e        cmd;
    logic [7:0]  port;
    logic [7:0]  data;
    logic [2:0]  row_index;
    logic [7:0]  row_value;
  } access_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [7:0]  port_i;
  logic [7:0]  data_i;
  logic [2:0]  row_index_i;
  logic [7:0]  row_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  read_value_o;
  logic        lamp_valid_o;
  logic [3:0]  lamp_address_o;
  logic [3:0]  lamp_value_o;
  logic        display_valid_o;
  logic [5:0]  display_position_o;
  logic [3:0]  display_digit_o;
  logic [16:0] solenoid_bits_o;
  logic [2:0]  switch_strobe_o;
  logic [9:0]  prom_address_o;

  pinball_cpu_io_port_decoder_core #(
    .NVRAM_WORDS (NVRAM_DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .port_i             (port_i),
    .data_i             (data_i),
    .row_index_i        (row_index_i),
    .row_value_i        (row_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_value_o       (read_value_o),
    .lamp_valid_o       (lamp_valid_o),
    .lamp_address_o     (lamp_address_o),
    .lamp_value_o       (lamp_value_o),
    .display_valid_o    (display_valid_o),
    .display_position_o (display_position_o),
    .display_digit_o    (display_digit_o),
    .solenoid_bits_o    (solenoid_bits_o),
    .switch_strobe_o    (switch_strobe_o),
    .prom_address_o     (prom_address_o)
  );

  // ---------------------------------------------------------------------------
  // Decoder state as the testbench sees it. Every accepted beat advances this
  // copy and yields the result the block must return for that beat.
  // ---------------------------------------------------------------------------
  logic [7:0]  dip_bank [3];
  logic [3:0]  acc;
  logic [3:0]  lamp_latch;
  int          lamp_strobe;          // -1 .. 11
  logic [2:0]  col_strobe;
  logic [9:0]  prom_addr;
  logic [16:0] solenoids;
  logic        ram_off;
  logic        ram_wm;
  logic [7:0]  ram_addr;
  logic [3:0]  nvram [NVRAM_DEPTH];
  logic [7:0]  switch_rows [8];
  int          cnt_a;
  int          cnt_b;

  result_t     decoded_q [$];        // results still owed by the block, oldest first
  int          beats_sent;
  int          mismatches;
  int          send_quiet;           // beats left in a gap-free stretch, sender
  int          stall_quiet;          // same for the receiver

  // Idle length for either side: mostly none, sometimes short, now and then
  // long, plus stretches where the side does not idle at all.
  function automatic int idle_length(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Work out the result of one access and advance the state copy
  function automatic result_t decode_access(access_t a);
    result_t    r;
    logic [3:0] chip;
    logic [3:0] line;
    logic       sos;
    logic       enable;
    logic       rw;
    logic [2:0] grp;
    logic [7:0] dip;
    logic [7:0] row;
    logic [3:0] inv;
    int         pos;
    r   = '0;
    pos = -1;
    case (a.cmd)
      CMD_PORT_WRITE: begin
        chip   = a.port[7:4];
        line   = a.port[3:0];
        sos    = a.data[4];
        enable = a.data[3];
        rw     = a.data[6];
        grp    = ~{a.data[7], a.data[5], a.data[4]};
        acc    = a.data[3:0];
        case (chip)
          CHIP_SWITCH: begin
            if (line < 6 && !enable) begin
              col_strobe = line[2:0] + 3'd1;
            end else if (!sos && line > 7 && col_strobe != 3'd0) begin
              // return lines 8..15 read row bits 0..7, a closed switch reads low
              row = switch_rows[col_strobe];
              acc = {~row[line[2:0]], acc[2:0]};
            end else begin
              col_strobe = 3'd0;
            end
          end
          CHIP_LAMP: begin
            if (rw) begin
              if (grp[0]) lamp_latch = acc;
              if (grp[1]) begin
                lamp_strobe = (acc < LAMP_STROBES) ? int'(acc) : -1;
                if (lamp_strobe > 0) begin
                  inv = ~lamp_latch;
                  // lamp nibble zero doubles as the game enable output
                  if (lamp_strobe == 1) solenoids[SOL_ENABLE] = (inv[1:0] == 2'b01);
                  r.lamp_valid   = 1'b1;
                  r.lamp_address = 4'(lamp_strobe - 1);
                  r.lamp_value   = inv;
                end
              end
              if (grp[2]) prom_addr[9:8] = acc[1:0];
            end else begin
              acc = 4'h0;
              if (lamp_strobe >= 0 && lamp_strobe < 3) begin
                dip = dip_bank[lamp_strobe];
                if (grp[0]) acc ^= dip[3:0];
                if (grp[1]) acc ^= dip[7:4];
              end
              if (grp[2]) acc = 4'h8 ^ switch_rows[7][7:4];
            end
          end
          CHIP_SOL: begin
            if (sos) begin
              if (line <= LINE_SOL_LAST) solenoids[line] = !enable;
              else if (line == LINE_RAM_DIS) ram_off = enable;
              else if (line == LINE_RAM_WM) ram_wm = enable;
            end
          end
          CHIP_NVRAM: begin
            if (rw) begin
              if (grp[0]) ram_addr[3:0] = acc;
              if (grp[1]) ram_addr[7:4] = acc;
              if (!ram_off && ram_wm && grp[2]) nvram[ram_addr % NVRAM_DEPTH] = acc;
            end else begin
              acc = 4'hf;
              if (!ram_off && grp[0]) acc = nvram[ram_addr % NVRAM_DEPTH];
            end
          end
          CHIP_DISPLAY: begin
            if (a.data[7:4] == DISP_CMD_B) begin
              if (cnt_b >= 3 && cnt_b <= 8) pos = cnt_b - 3;
              else if (cnt_b >= 11 && cnt_b <= 16) pos = cnt_b - 5;
              cnt_b--;
              if (cnt_b <= 0) cnt_b = COUNT_TOP;
            end else if (a.data[7:4] == DISP_CMD_A) begin
              if (cnt_a >= 1 && cnt_a <= 2) pos = cnt_a + 39;
              else if (cnt_a >= 3 && cnt_a <= 8) pos = cnt_a + 9;
              else if (cnt_a >= 9 && cnt_a <= 10) pos = cnt_a + 23;
              else if (cnt_a >= 11 && cnt_a <= 16) pos = cnt_a + 7;
              cnt_a--;
              if (cnt_a <= 0) cnt_a = COUNT_TOP;
            end
            if (pos >= 0) begin
              r.display_valid    = 1'b1;
              r.display_position = 6'(pos);
              r.display_digit    = acc;
            end
          end
          default: ;
        endcase
      end
      CMD_PROM_NIBBLE: begin
        if (a.port[0]) prom_addr[7:4] = ~a.data[3:0];
        else prom_addr[3:0] = ~a.data[3:0];
      end
      CMD_ROW_LOAD: switch_rows[a.row_index] = a.row_value;
      default: ;
    endcase
    r.read_value    = acc;
    r.solenoid_bits = solenoids;
    r.switch_strobe = col_strobe;
    r.prom_address  = prom_addr;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders. Fields the access does not use are random so that every
  // input bit toggles.
  // ---------------------------------------------------------------------------
  function automatic access_t port_access(logic [3:0] chip, logic [3:0] line,
                                          logic [7:0] data);
    access_t a;
    a.cmd       = CMD_PORT_WRITE;
    a.port      = {chip, line};
    a.data      = data;
    a.row_index = 3'($urandom);
    a.row_value = 8'($urandom);
    return a;
  endfunction

  function automatic access_t prom_access(logic odd, logic [7:0] data);
    access_t a;
    a.cmd       = CMD_PROM_NIBBLE;
    a.port      = {7'($urandom), odd};
    a.data      = data;
    a.row_index = 3'($urandom);
    a.row_value = 8'($urandom);
    return a;
  endfunction

  function automatic access_t row_access(logic [2:0] row, logic [7:0] value);
    access_t a;
    a.cmd       = CMD_ROW_LOAD;
    a.port      = 8'($urandom);
    a.data      = 8'($urandom);
    a.row_index = row;
    a.row_value = value;
    return a;
  endfunction

  // GPIO data byte: read/write flag, active-low group selects, nibble
  function automatic logic [7:0] gpio_data(logic rw, logic [2:0] grp, logic [3:0] nib);
    return {~grp[2], rw, ~grp[1], ~grp[0], nib};
  endfunction

  // Solenoid chip data byte with the strobe bit set
  function automatic logic [7:0] sol_data(logic enable);
    return {3'($urandom), 1'b1, enable, 3'($urandom)};
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit and receiver
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Far beyond the slowest legal run: every beat waiting out the longest gap
  // and the longest stall would still take well under a fifth of this.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // Stall the result channel at random, changing on the falling edge
  initial begin : receiver_stall
    int run_len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      run_len = idle_length(stall_quiet);
      if (run_len > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (run_len - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  task automatic report_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s) at %0t", what, $realtime);
      $display("  expected rd=%h lamp=%b/%h/%h disp=%b/%0d/%h sol=%h strb=%0d prom=%h",
               want.read_value, want.lamp_valid, want.lamp_address, want.lamp_value,
               want.display_valid, want.display_position, want.display_digit,
               want.solenoid_bits, want.switch_strobe, want.prom_address);
      $display("  actual   rd=%h lamp=%b/%h/%h disp=%b/%0d/%h sol=%h strb=%0d prom=%h",
               got.read_value, got.lamp_valid, got.lamp_address, got.lamp_value,
               got.display_valid, got.display_position, got.display_digit,
               got.solenoid_bits, got.switch_strobe, got.prom_address);
    end
  endtask

  // Match each result beat against the oldest outstanding prediction
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = {read_value_o, lamp_valid_o, lamp_address_o, lamp_value_o,
             display_valid_o, display_position_o, display_digit_o,
             solenoid_bits_o, switch_strobe_o, prom_address_o};
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected beat", '0, got);
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) report_mismatch("field", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Drive one access on the falling edge after a random gap, hold it until the
  // block takes it, then record what it must return. Valid stays high on exit
  // so that back-to-back beats need no second assignment in one step.
  task automatic send_access(input access_t a);
    int gap;
    gap = idle_length(send_quiet);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= a.cmd;
    port_i      <= a.port;
    data_i      <= a.data;
    row_index_i <= a.row_index;
    row_value_i <= a.row_value;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    decoded_q.push_back(decode_access(a));
    beats_sent++;
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // Load all three dip banks while the block is idle
  task automatic write_dip_banks(input logic [7:0] b0, b1, b2);
    drain_results();
    repeat (2) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DIP_ZERO;
    cfg_data_i  <= b0;
    @(negedge clk_i);
    cfg_index_i <= CFG_DIP_ONE;
    cfg_data_i  <= b1;
    @(negedge clk_i);
    cfg_index_i <= CFG_DIP_TWO;
    cfg_data_i  <= b2;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    dip_bank[0] = b0;
    dip_bank[1] = b1;
    dip_bank[2] = b2;
  endtask

  // Walk the lamp strobe over the dip banks and one strobe value past them, reading
  // low, high and both nibbles each time
  task automatic probe_dip_banks();
    for (int s = 0; s < 4; s++) begin
      send_access(port_access(CHIP_LAMP, 4'($urandom), gpio_data(1'b1, 3'b010, 4'(s))));
      for (int g = 1; g < 4; g++)
        send_access(port_access(CHIP_LAMP, 4'($urandom), gpio_data(1'b0, 3'(g), 4'($urandom))));
    end
  endtask

  // One short, mostly well-formed access sequence with random content
  task automatic run_scenario();
    int         kind;
    logic [3:0] nib;
    logic [3:0] chip;
    access_t    a;
    kind = $urandom_range(0, 19);
    case (kind)
      0, 1: begin
        // switch scan: select a column, then read some return lines
        if ($urandom_range(0, 2) == 0)
          send_access(row_access(3'($urandom_range(1, 6)), 8'($urandom)));
        send_access(port_access(CHIP_SWITCH, 4'($urandom_range(0, 5)),
                                {4'($urandom), 1'b0, 3'($urandom)}));
        repeat ($urandom_range(1, 4))
          send_access(port_access(CHIP_SWITCH, 4'($urandom_range(8, 15)),
                                  {3'($urandom), 1'b0, 4'($urandom)}));
        if ($urandom_range(0, 3) == 0)
          send_access(port_access(CHIP_SWITCH, 4'($urandom), {3'($urandom), 1'b1, 4'($urandom)}));
      end
      2: send_access(row_access(3'($urandom), 8'($urandom)));
      3, 4: begin
        // lamp update: latch the data, then strobe it out
        send_access(port_access(CHIP_LAMP, 4'($urandom),
                                gpio_data(1'b1, {1'($urandom), 2'b01}, 4'($urandom))));
        nib = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 11));
        send_access(port_access(CHIP_LAMP, 4'($urandom),
                                gpio_data(1'b1, {1'($urandom), 1'b1, 1'($urandom)}, nib)));
      end
      5, 6: begin
        // dip read: point the strobe at a bank, then read nibbles back
        nib = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        send_access(port_access(CHIP_LAMP, 4'($urandom), gpio_data(1'b1, 3'b010, nib)));
        repeat ($urandom_range(1, 3))
          send_access(port_access(CHIP_LAMP, 4'($urandom),
                                  gpio_data(1'b0, 3'($urandom), 4'($urandom))));
      end
      7: begin
        // special switches in row 7
        send_access(row_access(3'd7, 8'($urandom)));
        send_access(port_access(CHIP_LAMP, 4'($urandom),
                                gpio_data(1'b0, {1'b1, 2'($urandom)}, 4'($urandom))));
      end
      8: repeat ($urandom_range(1, 3))
           send_access(port_access(CHIP_SOL, 4'($urandom_range(0, 11)), sol_data(1'($urandom))));
      9: begin
        send_access(port_access(CHIP_SOL, $urandom_range(0, 1) ? LINE_RAM_DIS : LINE_RAM_WM,
                                sol_data(1'($urandom))));
      end
      10, 11: begin
        // NVRAM write: enable, write mode on, address, store, read back
        send_access(port_access(CHIP_SOL, LINE_RAM_DIS,
                                sol_data($urandom_range(0, 5) == 0)));
        send_access(port_access(CHIP_SOL, LINE_RAM_WM,
                                sol_data($urandom_range(0, 5) != 0)));
        send_access(port_access(CHIP_NVRAM, 4'($urandom), gpio_data(1'b1, 3'b001, 4'($urandom))));
        send_access(port_access(CHIP_NVRAM, 4'($urandom), gpio_data(1'b1, 3'b010, 4'($urandom))));
        send_access(port_access(CHIP_NVRAM, 4'($urandom),
                                gpio_data(1'b1, {1'b1, 2'($urandom)}, 4'($urandom))));
        send_access(port_access(CHIP_NVRAM, 4'($urandom),
                                gpio_data(1'b0, {2'($urandom), 1'b1}, 4'($urandom))));
      end
      12: begin
        // NVRAM read at a fresh address
        send_access(port_access(CHIP_NVRAM, 4'($urandom),
                                gpio_data(1'b1, {1'b0, 2'($urandom)}, 4'($urandom))));
        send_access(port_access(CHIP_NVRAM, 4'($urandom),
                                gpio_data(1'b0, 3'($urandom), 4'($urandom))));
      end
      13, 14: begin
        // display burst across both register countdowns
        repeat ($urandom_range(1, 10))
          send_access(port_access(CHIP_DISPLAY, 4'($urandom),
                                  {$urandom_range(0, 1) ? DISP_CMD_B : DISP_CMD_A,
                                   4'($urandom)}));
      end
      15: repeat ($urandom_range(1, 2))
            send_access(prom_access(1'($urandom), 8'($urandom)));
      default: begin
        // noise: anything at all, or a random byte to a known chip
        repeat ($urandom_range(1, 3)) begin
          a.cmd       = cmd_e'(2'($urandom));
          a.port      = 8'($urandom);
          a.data      = 8'($urandom);
          a.row_index = 3'($urandom);
          a.row_value = 8'($urandom);
          if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 4))
              0: chip = CHIP_SWITCH;
              1: chip = CHIP_LAMP;
              2: chip = CHIP_SOL;
              3: chip = CHIP_NVRAM;
              default: chip = CHIP_DISPLAY;
            endcase
            a.cmd       = CMD_PORT_WRITE;
            a.port[7:4] = chip;
          end
          send_access(a);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    access_t a;
    a = row_access(3'd0, 8'h00);
    a.cmd = CMD_IDLE;                                   // no-op access shows state
    send_access(a);
    send_access(prom_access(1'b0, 8'h00));
    send_access(prom_access(1'b1, 8'hff));              // high bits of nibble ignored
    send_access(row_access(3'd7, 8'hff));
    send_access(row_access(3'd3, 8'h5a));
    send_access(port_access(CHIP_SWITCH, 4'h2, 8'h00));  // column 3
    send_access(port_access(CHIP_SWITCH, 4'hf, 8'h00));  // row 3 bit 7
    send_access(port_access(CHIP_SWITCH, 4'h9, 8'hef));  // row 3 bit 1
    send_access(port_access(CHIP_SWITCH, 4'h7, 8'h10));  // drop the strobe
    send_access(port_access(CHIP_LAMP, 4'h0, gpio_data(1'b1, 3'b001, 4'h6)));
    send_access(port_access(CHIP_LAMP, 4'h0, gpio_data(1'b1, 3'b010, 4'h1)));  // game enable
    send_access(port_access(CHIP_LAMP, 4'h0, gpio_data(1'b1, 3'b011, 4'hb)));  // last lamp
    send_access(port_access(CHIP_LAMP, 4'h0, gpio_data(1'b1, 3'b110, 4'hc)));  // strobe parks
    send_access(port_access(CHIP_LAMP, 4'h0, gpio_data(1'b0, 3'b011, 4'h0)));  // no dip bank
    send_access(port_access(CHIP_LAMP, 4'h0, gpio_data(1'b1, 3'b010, 4'h2)));
    send_access(port_access(CHIP_LAMP, 4'h0, gpio_data(1'b0, 3'b011, 4'hf)));
    send_access(port_access(CHIP_LAMP, 4'h0, gpio_data(1'b0, 3'b100, 4'h0)));  // special row
    send_access(port_access(CHIP_SOL, 4'h0, 8'h10));
    send_access(port_access(CHIP_SOL, 4'hb, 8'hf7));
    send_access(port_access(CHIP_SOL, LINE_RAM_DIS, 8'h10));                   // NVRAM on
    send_access(port_access(CHIP_SOL, LINE_RAM_WM, 8'h18));                    // write mode
    send_access(port_access(CHIP_NVRAM, 4'h0, gpio_data(1'b1, 3'b011, 4'hf))); // address ff
    send_access(port_access(CHIP_NVRAM, 4'h0, gpio_data(1'b1, 3'b100, 4'ha)));
    send_access(port_access(CHIP_NVRAM, 4'h0, gpio_data(1'b0, 3'b001, 4'h0)));
    send_access(port_access(CHIP_DISPLAY, 4'h0, {DISP_CMD_B, 4'h7}));
    send_access(port_access(CHIP_DISPLAY, 4'h0, {DISP_CMD_A, 4'h0}));
    send_access(port_access(CHIP_DISPLAY, 4'h0, 8'h39));                       // not a display cmd
    send_access(port_access(4'hf, 4'hf, 8'hff));                               // no such chip
  endtask

  task automatic test_random_traffic(input int count);
    int target;
    target = beats_sent + count;
    while (beats_sent < target) run_scenario();
  endtask

  // Let the pipe run dry a few times with traffic on either side
  task automatic test_pause_until_drained();
    repeat (3) begin
      repeat ($urandom_range(3, 6)) run_scenario();
      drain_results();
      repeat ($urandom_range(5, 20)) @(negedge clk_i);
    end
  endtask

  task automatic test_dip_extremes();
    write_dip_banks(8'h00, 8'h00, 8'h00);
    probe_dip_banks();
    test_random_traffic(360);
    write_dip_banks(8'hff, 8'hff, 8'hff);
    probe_dip_banks();
    test_random_traffic(360);
    write_dip_banks(8'($urandom), 8'($urandom), 8'($urandom));
    probe_dip_banks();
    test_random_traffic(360);
  endtask

  initial begin : main
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_DIP_ZERO;
    cfg_data_i  = 8'h00;
    in_valid_i  = 1'b0;
    command_i   = CMD_IDLE;
    port_i      = 8'h00;
    data_i      = 8'h00;
    row_index_i = 3'd0;
    row_value_i = 8'h00;
    rst_ni      = 1'b0;

    // state after reset
    dip_bank    = '{8'h00, 8'h00, 8'h00};
    acc         = 4'h0;
    lamp_latch  = 4'h0;
    lamp_strobe = 0;
    col_strobe  = 3'd0;
    prom_addr   = 10'h000;
    solenoids   = 17'h00000;
    ram_off     = 1'b0;
    ram_wm      = 1'b0;
    ram_addr    = 8'h00;
    for (int i = 0; i < NVRAM_DEPTH; i++) nvram[i] = 4'h0;
    for (int i = 0; i < 8; i++) switch_rows[i] = 8'h00;
    cnt_a       = COUNT_TOP;
    cnt_b       = COUNT_TOP;
    beats_sent  = 0;
    mismatches  = 0;
    send_quiet  = 0;
    stall_quiet = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_dip_banks(8'($urandom), 8'($urandom), 8'($urandom));
    test_directed_cases();
    test_random_traffic(700);
    test_pause_until_drained();
    test_dip_extremes();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
